// ----- design/hqc_pkg.sv -----
// ----------------------------------------------------------------------------
// hqc_pkg: shared types, codes and the HSV color quantizer
// Request codes, the command struct that crosses the front/back queue and the
// exact integer 32-bin HSV quantization function.
// ----------------------------------------------------------------------------
package hqc_pkg;

    localparam int BIN_W   = 5;
    localparam int NBINS   = 32;
    localparam int PIX_W   = 8;
    localparam int REQ_W   = 2;
    localparam int DIST_W  = 2;
    localparam int CFG_W   = 11;
    localparam int COUNT_W = 32;

    localparam logic [REQ_W-1:0] REQ_PIXEL = 2'd0;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

    localparam logic [CFG_W-1:0] WIDTH_RESET = 11'd1024;

    typedef logic [BIN_W-1:0] bin_t;

    typedef struct packed {
        logic [REQ_W-1:0]  typ;
        bin_t              bin;
        logic [DIST_W-1:0] dist_idx;
    } hqc_cmd_t;

    // hue sector offset, num = hue * d
    function automatic logic [2:0] hue_offset(input logic signed [18:0] num,
                                              input logic signed [18:0] d);
        logic [2:0] off;
        begin
            if (num > 19'sd20 * d && num <= 19'sd45 * d)
                off = 3'd0;
            else if (num > 19'sd45 * d && num <= 19'sd75 * d)
                off = 3'd1;
            else if (num > 19'sd75 * d && num <= 19'sd155 * d)
                off = 3'd2;
            else if (num > 19'sd155 * d && num <= 19'sd210 * d)
                off = 3'd3;
            else if (num > 19'sd210 * d && num <= 19'sd270 * d)
                off = 3'd4;
            else if (num > 19'sd270 * d && num <= 19'sd330 * d)
                off = 3'd5;
            else
                off = 3'd6;
            return off;
        end
    endfunction

    function automatic bin_t quantize(input logic [PIX_W-1:0] r,
                                      input logic [PIX_W-1:0] g,
                                      input logic [PIX_W-1:0] b);
        logic [PIX_W-1:0]   mx;
        logic [PIX_W-1:0]   mn;
        logic [PIX_W-1:0]   d;
        logic [11:0]        mx10;
        logic [11:0]        d10;
        logic signed [18:0] sd;
        logic signed [18:0] sr;
        logic signed [18:0] sg;
        logic signed [18:0] sb;
        logic signed [18:0] num;
        bin_t               base;
        bin_t               q;
        begin
            mx = r;
            if (g > mx) mx = g;
            if (b > mx) mx = b;
            mn = r;
            if (g < mn) mn = g;
            if (b < mn) mn = b;
            d    = mx - mn;
            mx10 = 12'(mx) * 12'd10;
            d10  = 12'(d) * 12'd10;
            sd   = signed'({11'b0, d});
            sr   = signed'({11'b0, r});
            sg   = signed'({11'b0, g});
            sb   = signed'({11'b0, b});
            num  = '0;
            base = '0;
            if (mx10 <= 12'd255) begin
                q = 5'd0;
            end
            else if (d10 <= 12'(mx)) begin
                if (mx10 <= 12'd1020)
                    q = 5'd1;
                else if (mx10 <= 12'd1785)
                    q = 5'd2;
                else
                    q = 5'd3;
            end
            else begin
                if (({1'b0, d} << 1) <= {1'b0, mx})
                    base = (({1'b0, mx} << 1) <= 9'd255) ? 5'd4 : 5'd11;
                else
                    base = (({1'b0, mx} << 1) <= 9'd255) ? 5'd18 : 5'd25;
                if (r == mx) begin
                    num = 19'sd60 * (sg - sb);
                    if (num < 0)
                        num = num + 19'sd360 * sd;
                end
                else if (g == mx) begin
                    num = 19'sd120 * sd + 19'sd60 * (sb - sr);
                end
                else begin
                    num = 19'sd240 * sd + 19'sd60 * (sr - sg);
                end
                q = base + 5'(hue_offset(num, sd));
            end
            return q;
        end
    endfunction

endpackage

// ----- design/hqc_if.sv -----
// ----------------------------------------------------------------------------
// hqc_if: request and response channels
// Valid/ready channels carrying one request or one histogram read result.
// ----------------------------------------------------------------------------
interface hqc_req_if import hqc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [REQ_W-1:0]  req_type;
    logic [PIX_W-1:0]  blue;
    logic [PIX_W-1:0]  green;
    logic [PIX_W-1:0]  red;
    logic [BIN_W-1:0]  bin_index;
    logic [DIST_W-1:0] distance_index;

    modport source (output valid, req_type, blue, green, red, bin_index,
                    distance_index, input ready);
    modport sink (input valid, req_type, blue, green, red, bin_index,
                  distance_index, output ready);
endinterface

interface hqc_rsp_if import hqc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] match_count;

    modport source (output valid, match_count, input ready);
    modport sink (input valid, match_count, output ready);
endinterface

// ----- design/hqc_front.sv -----
// ----------------------------------------------------------------------------
// hqc_front: request intake, quantizer, line stores and window
// Tracks raster position, quantizes pixels, keeps a ring of row stores and a
// sliding square window, and emits per-distance match counts as commands.
// ----------------------------------------------------------------------------
module hqc_front import hqc_pkg::*; #(
    parameter int MAX_WIDTH = 1024,
    parameter int DISTANCES = 3,
    parameter int Q_DEPTH   = 8
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         cfg_wr_en,
    input  logic [CFG_W-1:0]                             cfg_wr_data,
    hqc_req_if.sink                                      req,
    input  logic [$clog2(Q_DEPTH+1)-1:0]                 q_free,
    output logic                                         push,
    output hqc_cmd_t                                     push_cmd,
    output logic [DISTANCES-1:0]                         push_en,
    output logic [DISTANCES-1:0][BIN_W-1:0]              push_ctr,
    output logic [DISTANCES-1:0][$clog2((2*DISTANCES-1)*(2*DISTANCES-1)+1)-1:0] push_cnt
);

    localparam int NROWS   = 2 * DISTANCES - 1;
    localparam int WIN     = NROWS;
    localparam int ROW_SAT = 2 * (DISTANCES - 1);
    localparam int ROW_W   = $clog2(ROW_SAT + 2);
    localparam int RING_W  = (NROWS > 1) ? $clog2(NROWS) : 1;
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int WID_W   = COL_W + 1;
    localparam int CNT_W   = $clog2(WIN * WIN + 1);

    function automatic logic [RING_W-1:0] ring_inc(input logic [RING_W-1:0] r);
        return (r == RING_W'(NROWS - 1)) ? '0 : r + 1'b1;
    endfunction

    function automatic logic [ROW_W-1:0] row_inc(input logic [ROW_W-1:0] r);
        return (r == ROW_W'(ROW_SAT)) ? r : r + 1'b1;
    endfunction

    logic [CFG_W-1:0]  width_reg;
    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [RING_W-1:0] ring_reg;

    logic [WID_W-1:0]  eff_w;
    logic              pre_adv;
    logic              post_adv;
    logic [COL_W-1:0]  col_use;
    logic [ROW_W-1:0]  row_use;
    logic [RING_W-1:0] ring_use;
    logic              acc;
    logic              known;

    // pipeline registers
    logic              s1_vld_reg;
    hqc_cmd_t          s1_cmd_reg;
    logic [PIX_W-1:0]  s1_r_reg;
    logic [PIX_W-1:0]  s1_g_reg;
    logic [PIX_W-1:0]  s1_b_reg;
    logic [COL_W-1:0]  s1_col_reg;
    logic [ROW_W-1:0]  s1_row_reg;
    logic [RING_W-1:0] s1_ring_reg;

    logic              s2_vld_reg;
    hqc_cmd_t          s2_cmd_reg;
    logic [COL_W-1:0]  s2_col_reg;
    logic [ROW_W-1:0]  s2_row_reg;
    logic [RING_W-1:0] s2_ring_reg;

    logic              s3_vld_reg;
    hqc_cmd_t          s3_cmd_reg;
    logic [COL_W-1:0]  s3_col_reg;
    logic [ROW_W-1:0]  s3_row_reg;

    logic                                   s4_vld_reg;
    hqc_cmd_t                               s4_cmd_reg;
    logic [DISTANCES-1:0]                   s4_en_reg;
    logic [DISTANCES-1:0][BIN_W-1:0]        s4_ctr_reg;
    logic [DISTANCES-1:0][WIN*WIN-1:0]      s4_match_reg;

    bin_t                                   q_bin;
    logic [NROWS-1:0][BIN_W-1:0]            rd_q;
    logic [WIN-1:0][BIN_W-1:0]              col_vec;
    logic [WIN-1:0][WIN-1:0][BIN_W-1:0]     win_reg;
    logic [DISTANCES-1:0]                   en3;
    logic [DISTANCES-1:0][BIN_W-1:0]        ctr3;
    logic [DISTANCES-1:0][WIN*WIN-1:0]      match3;
    logic [2:0]                             inflight;

    // position bookkeeping for an incoming pixel
    always_comb
    begin
        if (width_reg == '0)
            eff_w = WID_W'(1);
        else if (int'(width_reg) > MAX_WIDTH)
            eff_w = WID_W'(MAX_WIDTH);
        else
            eff_w = WID_W'(width_reg);
        pre_adv  = ({1'b0, col_reg} >= eff_w);
        col_use  = pre_adv ? '0 : col_reg;
        ring_use = pre_adv ? ring_inc(ring_reg) : ring_reg;
        row_use  = pre_adv ? row_inc(row_reg) : row_reg;
        post_adv = (({1'b0, col_use} + WID_W'(1)) >= eff_w);
    end

    assign inflight  = 3'($countones({s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg}));
    assign req.ready = ((int'(inflight) + 1) <= int'(q_free));
    assign acc       = req.valid && req.ready;
    assign known     = (req.req_type == REQ_PIXEL) || (req.req_type == REQ_READ) ||
                       (req.req_type == REQ_CLEAR);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= WIDTH_RESET;
            col_reg   <= '0;
            row_reg   <= '0;
            ring_reg  <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                width_reg <= cfg_wr_data;
            if (acc)
            begin
                case (req.req_type)
                    REQ_PIXEL:
                    begin
                        if (post_adv)
                        begin
                            col_reg  <= '0;
                            ring_reg <= ring_inc(ring_use);
                            row_reg  <= row_inc(row_use);
                        end
                        else
                        begin
                            col_reg  <= col_use + 1'b1;
                            ring_reg <= ring_use;
                            row_reg  <= row_use;
                        end
                    end
                    REQ_CLEAR:
                    begin
                        col_reg  <= '0;
                        row_reg  <= '0;
                        ring_reg <= '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= acc && known;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
        end
    end

    // stage 1: capture
    always_ff @(posedge clk)
    begin
        s1_cmd_reg.typ      <= req.req_type;
        s1_cmd_reg.bin      <= req.bin_index;
        s1_cmd_reg.dist_idx <= req.distance_index;
        s1_r_reg            <= req.red;
        s1_g_reg            <= req.green;
        s1_b_reg            <= req.blue;
        s1_col_reg          <= col_use;
        s1_row_reg          <= row_use;
        s1_ring_reg         <= ring_use;
    end

    assign q_bin = quantize(s1_r_reg, s1_g_reg, s1_b_reg);

    // ring of row stores, current slot written, all slots read at the column
    for (genvar s = 0; s < NROWS; s++)
    begin : g_line
        logic [BIN_W-1:0] mem [MAX_WIDTH];

        always_ff @(posedge clk)
        begin
            if (s1_vld_reg && s1_cmd_reg.typ == REQ_PIXEL && s1_ring_reg == RING_W'(s))
                mem[s1_col_reg] <= q_bin;
            rd_q[s] <= mem[s1_col_reg];
        end
    end

    // stage 2
    always_ff @(posedge clk)
    begin
        s2_cmd_reg      <= s1_cmd_reg;
        if (s1_cmd_reg.typ == REQ_PIXEL)
            s2_cmd_reg.bin <= q_bin;
        s2_col_reg      <= s1_col_reg;
        s2_row_reg      <= s1_row_reg;
        s2_ring_reg     <= s1_ring_reg;
    end

    // new window column: current bin on top, older rows below
    always_comb
    begin
        logic [RING_W:0] slot;
        slot       = '0;
        col_vec    = '0;
        col_vec[0] = s2_cmd_reg.bin;
        for (int dr = 1; dr < WIN; dr++)
        begin
            slot = (RING_W+1)'(s2_ring_reg) + (RING_W+1)'(NROWS - dr);
            if (slot >= (RING_W+1)'(NROWS))
                slot = slot - (RING_W+1)'(NROWS);
            col_vec[dr] = rd_q[slot[RING_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else if (s2_vld_reg && s2_cmd_reg.typ == REQ_PIXEL)
        begin
            for (int dr = 0; dr < WIN; dr++)
            begin
                win_reg[dr][0] <= col_vec[dr];
                for (int dc = 1; dc < WIN; dc++)
                    win_reg[dr][dc] <= win_reg[dr][dc-1];
            end
        end
    end

    // stage 3: window compares, k = 0 is the center alone
    always_ff @(posedge clk)
    begin
        s3_cmd_reg <= s2_cmd_reg;
        s3_col_reg <= s2_col_reg;
        s3_row_reg <= s2_row_reg;
    end

    always_comb
    begin
        en3    = '0;
        ctr3   = '0;
        match3 = '0;
        for (int k = 0; k < DISTANCES; k++)
        begin
            ctr3[k] = win_reg[k][k];
            en3[k]  = (s3_cmd_reg.typ == REQ_PIXEL) && (int'(s3_row_reg) >= 2 * k) &&
                      (int'(s3_col_reg) >= 2 * k);
            for (int dr = 0; dr < WIN; dr++)
                for (int dc = 0; dc < WIN; dc++)
                    match3[k][dr*WIN+dc] = (dr <= 2 * k) && (dc <= 2 * k) &&
                                           (win_reg[dr][dc] == ctr3[k]);
        end
    end

    // stage 4: population counts
    always_ff @(posedge clk)
    begin
        s4_cmd_reg   <= s3_cmd_reg;
        s4_en_reg    <= en3;
        s4_ctr_reg   <= ctr3;
        s4_match_reg <= match3;
    end

    always_comb
    begin
        for (int k = 0; k < DISTANCES; k++)
            push_cnt[k] = CNT_W'($countones(s4_match_reg[k]));
    end

    assign push     = s4_vld_reg;
    assign push_cmd = s4_cmd_reg;
    assign push_en  = s4_en_reg;
    assign push_ctr = s4_ctr_reg;

endmodule

// ----- design/hqc_queue.sv -----
// ----------------------------------------------------------------------------
// hqc_queue: command queue between front and back
// Small register FIFO; reports free slots so the front can hold off intake.
// ----------------------------------------------------------------------------
module hqc_queue import hqc_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    input  logic [WIDTH-1:0]               push_data,
    input  logic                           pop,
    output logic [WIDTH-1:0]               head_data,
    output logic                           empty,
    output logic [$clog2(DEPTH+1)-1:0]     free
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign empty     = (count_reg == '0);
    assign free      = CNT_W'(DEPTH) - count_reg;
    assign head_data = data_reg[rd_ptr_reg];
    assign do_pop    = pop && !empty;

    always_ff @(posedge clk)
    begin
        if (push)
            data_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (do_pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ----- design/hqc_back.sv -----
// ----------------------------------------------------------------------------
// hqc_back: histogram banks and result buffer
// One 32-entry bank per distance, read-modify-write with saturation and a
// forward path for back-to-back hits; reads go out through a small FIFO.
// ----------------------------------------------------------------------------
module hqc_back import hqc_pkg::*; #(
    parameter int DISTANCES = 3,
    parameter int O_DEPTH   = 4
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         q_empty,
    input  hqc_cmd_t                                     head_cmd,
    input  logic [DISTANCES-1:0]                         head_en,
    input  logic [DISTANCES-1:0][BIN_W-1:0]              head_ctr,
    input  logic [DISTANCES-1:0][$clog2((2*DISTANCES-1)*(2*DISTANCES-1)+1)-1:0] head_cnt,
    output logic                                         pop,
    hqc_rsp_if.source                                    rsp
);

    localparam int WIN   = 2 * DISTANCES - 1;
    localparam int CNT_W = $clog2(WIN * WIN + 1);
    localparam int OP_W  = (O_DEPTH > 1) ? $clog2(O_DEPTH) : 1;
    localparam int OC_W  = $clog2(O_DEPTH + 1);

    logic                                 b1_vld_reg;
    hqc_cmd_t                             b1_cmd_reg;
    logic [DISTANCES-1:0]                 b1_en_reg;
    logic [DISTANCES-1:0][CNT_W-1:0]      b1_cnt_reg;
    logic [DISTANCES-1:0][BIN_W-1:0]      b1_addr_reg;

    logic                                 b2_vld_reg;
    hqc_cmd_t                             b2_cmd_reg;
    logic [DISTANCES-1:0]                 b2_en_reg;
    logic [DISTANCES-1:0][CNT_W-1:0]      b2_cnt_reg;
    logic [DISTANCES-1:0][BIN_W-1:0]      b2_addr_reg;
    logic [DISTANCES-1:0]                 fwd_reg;
    logic [DISTANCES-1:0][COUNT_W-1:0]    fwd_data_reg;
    logic [DISTANCES-1:0][NBINS-1:0]      vld_reg;

    logic [DISTANCES-1:0][COUNT_W-1:0]    bank_q;
    logic [DISTANCES-1:0][COUNT_W-1:0]    eff;
    logic [DISTANCES-1:0]                 wr_en;
    logic [DISTANCES-1:0][COUNT_W-1:0]    wr_data;
    logic [COUNT_W-1:0]                   rd_result;
    logic                                 rd_push;

    logic [COUNT_W-1:0]                   ofifo_reg [O_DEPTH];
    logic [OP_W-1:0]                      owr_reg;
    logic [OP_W-1:0]                      ord_reg;
    logic [OC_W-1:0]                      ocount_reg;
    logic                                 opop;
    logic [OC_W+1:0]                      committed;

    function automatic logic [OP_W-1:0] optr_inc(input logic [OP_W-1:0] p);
        return (p == OP_W'(O_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // every read in flight keeps a slot in the result buffer
    assign committed = (OC_W+2)'(ocount_reg) +
                       (OC_W+2)'(b1_vld_reg && b1_cmd_reg.typ == REQ_READ) +
                       (OC_W+2)'(b2_vld_reg && b2_cmd_reg.typ == REQ_READ);
    assign pop       = !q_empty && (committed < (OC_W+2)'(O_DEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_vld_reg <= 1'b0;
            b2_vld_reg <= 1'b0;
        end
        else
        begin
            b1_vld_reg <= pop;
            b2_vld_reg <= b1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b1_cmd_reg <= head_cmd;
        b1_en_reg  <= head_en;
        b1_cnt_reg <= head_cnt;
        for (int k = 0; k < DISTANCES; k++)
            b1_addr_reg[k] <= (head_cmd.typ == REQ_READ) ? head_cmd.bin : head_ctr[k];
        b2_cmd_reg   <= b1_cmd_reg;
        b2_en_reg    <= b1_en_reg;
        b2_cnt_reg   <= b1_cnt_reg;
        b2_addr_reg  <= b1_addr_reg;
        // the item now reading may hit the entry being written this cycle
        for (int k = 0; k < DISTANCES; k++)
            fwd_reg[k] <= wr_en[k] && (b1_addr_reg[k] == b2_addr_reg[k]);
        fwd_data_reg <= wr_data;
    end

    for (genvar k = 0; k < DISTANCES; k++)
    begin : g_bank
        logic [COUNT_W-1:0] mem [NBINS];

        always_ff @(posedge clk)
        begin
            if (wr_en[k])
                mem[b2_addr_reg[k]] <= wr_data[k];
            bank_q[k] <= mem[b1_addr_reg[k]];
        end
    end

    always_comb
    begin
        logic [COUNT_W:0] sum;
        sum       = '0;
        rd_result = '0;
        for (int k = 0; k < DISTANCES; k++)
        begin
            if (fwd_reg[k])
                eff[k] = fwd_data_reg[k];
            else if (vld_reg[k][b2_addr_reg[k]])
                eff[k] = bank_q[k];
            else
                eff[k] = '0;
            wr_en[k]   = b2_vld_reg && (b2_cmd_reg.typ == REQ_PIXEL) && b2_en_reg[k];
            sum        = {1'b0, eff[k]} + (COUNT_W+1)'(b2_cnt_reg[k]);
            wr_data[k] = sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];
            if (int'(b2_cmd_reg.dist_idx) == k)
                rd_result = eff[k];
        end
    end

    assign rd_push = b2_vld_reg && (b2_cmd_reg.typ == REQ_READ);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (b2_vld_reg && b2_cmd_reg.typ == REQ_CLEAR)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < DISTANCES; k++)
                if (wr_en[k])
                    vld_reg[k][b2_addr_reg[k]] <= 1'b1;
        end
    end

    // result buffer
    assign opop            = rsp.valid && rsp.ready;
    assign rsp.valid       = (ocount_reg != '0);
    assign rsp.match_count = ofifo_reg[ord_reg];

    always_ff @(posedge clk)
    begin
        if (rd_push)
            ofifo_reg[owr_reg] <= rd_result;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owr_reg    <= '0;
            ord_reg    <= '0;
            ocount_reg <= '0;
        end
        else
        begin
            if (rd_push)
                owr_reg <= optr_inc(owr_reg);
            if (opop)
                ord_reg <= optr_inc(ord_reg);
            if (rd_push && !opop)
                ocount_reg <= ocount_reg + 1'b1;
            else if (opop && !rd_push)
                ocount_reg <= ocount_reg - 1'b1;
        end
    end

endmodule

// ----- design/hsv_quantized_color_correlogram.sv -----
// ----------------------------------------------------------------------------
// hsv_quantized_color_correlogram: 32-bin HSV color autocorrelogram
// Throughput: one transaction per cycle (pixel, read or clear) while the queue has room.
// Path: once accepted, a read passes the four front stages, the queue,
//   the two-stage bank update and the result buffer before it is offered.
// Reset: histogram entries read as zero via per-entry valid bits, positions
//   and window cleared at once; row stores hold no reset value.
// ----------------------------------------------------------------------------
module hsv_quantized_color_correlogram import hqc_pkg::*; #(
    parameter int MAX_WIDTH = 1024,
    parameter int DISTANCES = 3
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data,
    hqc_req_if.sink          req,
    hqc_rsp_if.source        rsp
);

    localparam int WIN     = 2 * DISTANCES - 1;
    localparam int CNT_W   = $clog2(WIN * WIN + 1);
    localparam int Q_DEPTH = 8;
    localparam int O_DEPTH = 4;
    localparam int CMD_W   = $bits(hqc_cmd_t);
    localparam int QW      = CMD_W + DISTANCES + DISTANCES * BIN_W + DISTANCES * CNT_W;

    logic                            push;
    hqc_cmd_t                        push_cmd;
    logic [DISTANCES-1:0]            push_en;
    logic [DISTANCES-1:0][BIN_W-1:0] push_ctr;
    logic [DISTANCES-1:0][CNT_W-1:0] push_cnt;
    logic                            pop;
    logic                            q_empty;
    logic [$clog2(Q_DEPTH+1)-1:0]    q_free;
    logic [QW-1:0]                   head_data;
    hqc_cmd_t                        head_cmd;
    logic [DISTANCES-1:0]            head_en;
    logic [DISTANCES-1:0][BIN_W-1:0] head_ctr;
    logic [DISTANCES-1:0][CNT_W-1:0] head_cnt;

    hqc_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .DISTANCES (DISTANCES),
        .Q_DEPTH   (Q_DEPTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req),
        .q_free      (q_free),
        .push        (push),
        .push_cmd    (push_cmd),
        .push_en     (push_en),
        .push_ctr    (push_ctr),
        .push_cnt    (push_cnt)
    );

    hqc_queue #(
        .WIDTH (QW),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_cmd, push_en, push_ctr, push_cnt}),
        .pop       (pop),
        .head_data (head_data),
        .empty     (q_empty),
        .free      (q_free)
    );

    assign {head_cmd, head_en, head_ctr, head_cnt} = head_data;

    hqc_back #(
        .DISTANCES (DISTANCES),
        .O_DEPTH   (O_DEPTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .head_cmd (head_cmd),
        .head_en  (head_en),
        .head_ctr (head_ctr),
        .head_cnt (head_cnt),
        .pop      (pop),
        .rsp      (rsp)
    );

endmodule
